// ===== design/mcc_pkg.sv =====
`default_nettype none

package mcc_pkg;

  // Default sizes of the coin store and the amount table.
  localparam int MAX_COINS_DEF  = 16;
  localparam int MAX_AMOUNT_DEF = 4095;

  // Widths of the item fields.
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 12;
  localparam int RESULT_W = 13;

  localparam int VALUE_MAX = (1 << VALUE_W) - 1;

  // Item kinds. The fourth code means nothing and is ignored.
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SOLVE = 2'd2;

  localparam logic signed [RESULT_W-1:0] RESULT_NEG_ONE = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_clear;
    logic do_add;
    logic load_solve;
    logic init;
    logic issue;
    logic write_amt;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quick;
    logic k_last;
    logic pipe_busy;
    logic a_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/mcc_ram.sv =====
`default_nettype none

module mcc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/mcc_ctrl.sv =====
`default_nettype none

module mcc_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [mcc_pkg::KIND_W-1:0] kind_i,
  input  wire mcc_pkg::stat_t             stat_i,
  output logic                            in_ready_o,
  output mcc_pkg::cmd_t                   cmd_o
);

  import mcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_DRAIN,
    S_WRITE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_CLEAR: cmd_o.do_clear = 1'b1;
            KIND_ADD:   cmd_o.do_add = 1'b1;
            KIND_SOLVE: begin
              cmd_o.load_solve = 1'b1;
              state_d = stat_i.quick ? S_DONE : S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.k_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write_amt = 1'b1;
        state_d = stat_i.a_last ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mcc_dp.sv =====
`default_nettype none

module mcc_dp #(
  parameter int MAX_COINS  = mcc_pkg::MAX_COINS_DEF,
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [mcc_pkg::VALUE_W-1:0]         coin_value_i,
  input  wire logic [mcc_pkg::VALUE_W-1:0]         target_amount_i,
  input  wire logic                                out_ready_i,
  input  wire mcc_pkg::cmd_t                       cmd_i,
  output mcc_pkg::stat_t                           stat_o,
  output logic                                     out_valid_o,
  output logic signed [mcc_pkg::RESULT_W-1:0]      min_coins_o,
  output logic                                     solvable_o
);

  import mcc_pkg::*;

  // Targets are at most VALUE_MAX, so the table never needs more entries.
  localparam int TABLE_MAX = (MAX_AMOUNT < VALUE_MAX) ? MAX_AMOUNT : VALUE_MAX;
  localparam int AW        = $clog2(TABLE_MAX + 1);
  localparam int VW        = $clog2(TABLE_MAX + 2);
  localparam int CW        = $clog2(MAX_COINS + 1);
  localparam int IW        = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam logic [VW-1:0] SENT = VW'(TABLE_MAX + 1);

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      k_q, k_d;
  logic [AW-1:0]      a_q, a_d;
  logic [AW-1:0]      target_q, target_d;
  logic [VW-1:0]      min_q, min_d;
  logic [VW-1:0]      res_q, res_d;
  logic               p1_q, p1_d;
  logic               p2_q, p2_d;
  logic               out_valid_q, out_valid_d;
  logic signed [RESULT_W-1:0] out_min_q, out_min_d;
  logic               out_solv_q, out_solv_d;

  logic               coin_we;
  logic [VALUE_W-1:0] coin_rdata;
  logic               best_we;
  logic [AW-1:0]      best_waddr;
  logic [VW-1:0]      best_wdata;
  logic [AW-1:0]      best_raddr;
  logic [VW-1:0]      best_rdata;
  logic [VALUE_W-1:0] diff;
  logic               coin_fits;
  logic [VW-1:0]      cand;

  assign coin_we = cmd_i.do_add && (coin_value_i != '0) && (count_q < CW'(MAX_COINS));

  mcc_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_COINS),
    .AW   (IW)
  ) u_coin_ram (
    .clk_i  (clk_i),
    .we_i   (coin_we),
    .waddr_i(count_q[IW-1:0]),
    .wdata_i(coin_value_i),
    .raddr_i(k_q[IW-1:0]),
    .rdata_o(coin_rdata)
  );

  // A coin read issued last cycle is compared against the current amount;
  // when it fits, the entry for the remainder is read.
  assign coin_fits  = (coin_rdata <= VALUE_W'(a_q));
  assign diff       = VALUE_W'(a_q) - coin_rdata;
  assign best_raddr = diff[AW-1:0];

  assign best_we    = cmd_i.init || cmd_i.write_amt;
  assign best_waddr = cmd_i.init ? '0 : a_q;
  assign best_wdata = cmd_i.init ? '0 : min_q;

  mcc_ram #(
    .WIDTH(VW),
    .DEPTH(TABLE_MAX + 1),
    .AW   (AW)
  ) u_best_ram (
    .clk_i  (clk_i),
    .we_i   (best_we),
    .waddr_i(best_waddr),
    .wdata_i(best_wdata),
    .raddr_i(best_raddr),
    .rdata_o(best_rdata)
  );

  assign cand = best_rdata + VW'(1);

  always_comb begin
    count_d     = count_q;
    k_d         = k_q;
    a_d         = a_q;
    target_d    = target_q;
    min_d       = min_q;
    res_d       = res_q;
    p1_d        = cmd_i.issue;
    p2_d        = p1_q && coin_fits;
    out_valid_d = out_valid_q;
    out_min_d   = out_min_q;
    out_solv_d  = out_solv_q;

    if (cmd_i.do_clear) begin
      count_d = '0;
    end
    if (coin_we) begin
      count_d = count_q + CW'(1);
    end

    if (cmd_i.load_solve) begin
      target_d = AW'(target_amount_i);
      res_d    = (target_amount_i == '0) ? '0 : SENT;
    end

    if (cmd_i.init || cmd_i.write_amt) begin
      k_d   = '0;
      min_d = SENT;
      a_d   = cmd_i.init ? AW'(1) : a_q + AW'(1);
    end else begin
      if (cmd_i.issue) begin
        k_d = k_q + CW'(1);
      end
      if (p2_q && (best_rdata != SENT) && (cand < min_q)) begin
        min_d = cand;
      end
    end

    if (cmd_i.write_amt && (a_q == target_q)) begin
      res_d = min_q;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_solv_d  = (res_q != SENT);
      out_min_d   = (res_q == SENT) ? RESULT_NEG_ONE : $signed(RESULT_W'(res_q));
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    a_q        <= a_d;
    target_q   <= target_d;
    min_q      <= min_d;
    res_q      <= res_d;
    out_min_q  <= out_min_d;
    out_solv_q <= out_solv_d;
  end

  assign stat_o.quick     = (target_amount_i == '0) ||
                            (target_amount_i > VALUE_W'(TABLE_MAX)) ||
                            (count_q == '0);
  assign stat_o.k_last    = (k_q == count_q - CW'(1));
  assign stat_o.pipe_busy = p1_q || p2_q;
  assign stat_o.a_last    = (a_q == target_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign min_coins_o = out_min_q;
  assign solvable_o  = out_solv_q;

endmodule

`default_nettype wire

// ===== design/min_coin_change_dp_top.sv =====
`default_nettype none

// Channel  Direction  Handshake              Fields
// input    in         in_valid_i/in_ready_o  kind_i, coin_value_i, target_amount_i
// output   out        out_valid_o/out_ready_i min_coins_o, solvable_o
//
// Clear and add items are handled straight from idle; kind 3 is taken and dropped.
// A solve streams, for each amount up to the target, one coin-store read and
// one table read per cycle through a two-stage pipeline, then writes its
// table entry. Targets of zero, targets above the table and an empty coin
// store skip the scan and go straight to the result.
// No clearing pass after reset; one item is in work at a time, and a finished
// result waits in the output register while out_ready_i is low.
module min_coin_change_dp_top #(
  parameter int MAX_COINS  = mcc_pkg::MAX_COINS_DEF,
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [mcc_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [mcc_pkg::VALUE_W-1:0]    coin_value_i,
  input  wire logic [mcc_pkg::VALUE_W-1:0]    target_amount_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [mcc_pkg::RESULT_W-1:0] min_coins_o,
  output logic                                solvable_o
);

  import mcc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mcc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .kind_i    (kind_i),
    .stat_i    (stat),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  mcc_dp #(
    .MAX_COINS (MAX_COINS),
    .MAX_AMOUNT(MAX_AMOUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .coin_value_i   (coin_value_i),
    .target_amount_i(target_amount_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .min_coins_o    (min_coins_o),
    .solvable_o     (solvable_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mcc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int UNREACHABLE = MAX_AMOUNT_DEF + 1;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] coin_value;
    logic [VALUE_W-1:0] target_amount;
    bit                 drain;
  } coin_item_t;

  typedef struct {
    logic signed [RESULT_W-1:0] min_coins;
    logic                       solvable;
  } change_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] kind = KIND_CLEAR;
  logic [VALUE_W-1:0] coin_value = '0;
  logic [VALUE_W-1:0] target_amount = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RESULT_W-1:0] min_coins;
  logic solvable;

  coin_item_t  pending_q[$];
  change_res_t change_q[$];

  // Shadow copy of the coin store and the amount table.
  int coin_list[MAX_COINS_DEF];
  int coin_cnt = 0;
  int best_amt[0:MAX_AMOUNT_DEF];

  int    send_idle_pct = 14;
  int    recv_idle_pct = 81;
  bit    hold_req = 1'b0;
  bit    hold_done = 1'b0;
  int    hold_cnt = 0;
  bit    failed = 1'b0;
  longint cycle_cnt = 0;
  longint cycle_limit = 50000;

  min_coin_change_dp_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (kind),
    .coin_value_i    (coin_value),
    .target_amount_i (target_amount),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .min_coins_o     (min_coins),
    .solvable_o      (solvable)
  );

  always #10 clk = ~clk;

  function automatic change_res_t fewest_coins(input int target);
    change_res_t res;
    int cand;
    best_amt[0] = 0;
    for (int a = 1; a <= target; a++) begin
      best_amt[a] = UNREACHABLE;
      for (int k = 0; k < coin_cnt; k++) begin
        if (coin_list[k] <= a && best_amt[a - coin_list[k]] != UNREACHABLE) begin
          cand = best_amt[a - coin_list[k]] + 1;
          if (cand < best_amt[a]) best_amt[a] = cand;
        end
      end
    end
    if (best_amt[target] == UNREACHABLE) begin
      res.min_coins = RESULT_NEG_ONE;
      res.solvable  = 1'b0;
    end else begin
      res.min_coins = RESULT_W'(best_amt[target]);
      res.solvable  = 1'b1;
    end
    return res;
  endfunction

  // Updates the shadow coin store for one accepted item and queues its answer.
  function automatic void track_item(input logic [KIND_W-1:0] k,
                                     input logic [VALUE_W-1:0] coin,
                                     input logic [VALUE_W-1:0] target);
    case (k)
      KIND_CLEAR: coin_cnt = 0;
      KIND_ADD: begin
        if (coin != 0 && coin_cnt < MAX_COINS_DEF) begin
          coin_list[coin_cnt] = int'(coin);
          coin_cnt++;
        end
      end
      KIND_SOLVE: change_q.push_back(fewest_coins(int'(target)));
      default: ;
    endcase
  endfunction

  function automatic void push_item(input logic [KIND_W-1:0] k,
                                    input logic [VALUE_W-1:0] coin,
                                    input logic [VALUE_W-1:0] target,
                                    input bit drain = 1'b0);
    coin_item_t it;
    it.kind          = k;
    it.coin_value    = coin;
    it.target_amount = target;
    it.drain         = drain;
    pending_q.push_back(it);
    // Each item widens the run's limit; a solve widens it further with its target.
    cycle_limit += 400;
    if (k == KIND_SOLVE) cycle_limit += 4 * (longint'(target) * (MAX_COINS_DEF + 4) + 3);
  endfunction

  task automatic add_random_items(input int n);
    int sel;
    int pick;
    logic [VALUE_W-1:0] coin;
    logic [VALUE_W-1:0] target;
    for (int i = 0; i < n; i++) begin
      sel    = $urandom_range(99);
      pick   = $urandom_range(99);
      coin   = VALUE_W'($urandom_range(0, VALUE_MAX));
      target = VALUE_W'($urandom_range(0, VALUE_MAX));
      if (sel < 8) begin
        push_item(KIND_CLEAR, coin, target);
      end else if (sel < 45) begin
        if (pick < 5) coin = '0;
        else if (pick < 70) coin = VALUE_W'($urandom_range(1, 24));
        else coin = VALUE_W'($urandom_range(1, VALUE_MAX));
        push_item(KIND_ADD, coin, target);
      end else if (sel < 92) begin
        // Most solves stay small so that the run stays short.
        if (pick < 85) target = VALUE_W'($urandom_range(0, 63));
        else if (pick < 96) target = VALUE_W'($urandom_range(64, 511));
        else target = VALUE_W'($urandom_range(512, VALUE_MAX));
        push_item(KIND_SOLVE, coin, target);
      end else begin
        push_item(KIND_UNUSED, coin, target);
      end
    end
  endtask

  // Sender: offers the next pending item at random while the channel is free.
  always @(posedge clk or negedge rst_n) begin : item_driver
    coin_item_t nxt;
    logic take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_item(kind, coin_value, target_amount);
      if (!in_valid || in_ready) begin
        take = pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (take && pending_q[0].drain && change_q.size() != 0) take = 1'b0;
        if (take) begin
          nxt = pending_q.pop_front();
          kind          <= nxt.kind;
          coin_value    <= nxt.coin_value;
          target_amount <= nxt.target_amount;
        end
        in_valid <= take;
      end
    end
  end

  // Receiver: checks each result against the oldest pending answer.
  always @(posedge clk or negedge rst_n) begin : result_check
    change_res_t want;
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (change_q.size() == 0) begin
          $error("result with no solve pending: min_coins %0d, solvable %0b",
                 min_coins, solvable);
          failed = 1'b1;
        end else begin
          want = change_q.pop_front();
          if (min_coins !== want.min_coins) begin
            $error("min_coins mismatch: expected %0d, actual %0d", want.min_coins, min_coins);
            failed = 1'b1;
          end
          if (solvable !== want.solvable) begin
            $error("solvable mismatch: expected %0b, actual %0b", want.solvable, solvable);
            failed = 1'b1;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_cnt  = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        rdy = 1'b0;
      end else begin
        rdy = $urandom_range(99) >= recv_idle_pct;
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_limit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty store, zero and oversized coins, the full table,
    // an unused kind, a full store with a repeated coin, and a clear.
    push_item(KIND_SOLVE, '0, '0);
    push_item(KIND_SOLVE, '0, VALUE_MAX);
    push_item(KIND_ADD, '0, VALUE_MAX);
    push_item(KIND_ADD, 12'd3, '0);
    push_item(KIND_ADD, VALUE_MAX, '0);
    push_item(KIND_SOLVE, '0, VALUE_MAX);
    push_item(KIND_SOLVE, VALUE_MAX, 12'd11);
    push_item(KIND_UNUSED, VALUE_MAX, VALUE_MAX);
    push_item(KIND_ADD, 12'd2, '0);
    push_item(KIND_ADD, 12'd2, '0);
    for (int i = 0; i < 12; i++) begin
      push_item(KIND_ADD, VALUE_W'($urandom_range(7, VALUE_MAX)), '0);
    end
    // The store is full now, so this coin must not count.
    push_item(KIND_ADD, 12'd1, '0);
    push_item(KIND_SOLVE, '0, 12'd1);
    push_item(KIND_SOLVE, '0, 12'd100);
    push_item(KIND_CLEAR, VALUE_MAX, VALUE_MAX, 1'b1);
    push_item(KIND_SOLVE, '0, 12'd5);
    add_random_items(25);
    while (pending_q.size() != 0) @(posedge clk);

    send_idle_pct <= 81;
    recv_idle_pct <= 14;
    push_item(KIND_SOLVE, '0, VALUE_W'($urandom_range(0, 63)), 1'b1);
    add_random_items(26);
    while (pending_q.size() != 0) @(posedge clk);

    // No idling; the receiver holds off once so that the block backs up.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_req      <= 1'b1;
    cycle_limit   += 2 * HOLD_CYCLES;
    push_item(KIND_CLEAR, '0, '0);
    push_item(KIND_ADD, VALUE_W'($urandom_range(1, 5)), '0);
    push_item(KIND_ADD, VALUE_W'($urandom_range(2, 9)), '0);
    for (int i = 0; i < 6; i++) push_item(KIND_SOLVE, '0, VALUE_W'($urandom_range(0, 15)));
    add_random_items(12);

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (change_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed && change_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
